/* design/ptq_pkg.sv */
// Shared types and constants for the periodic timer queue.
// No dependencies; every other file in this block but ptq_ram uses it.
package ptq_pkg;

  localparam int MAX_TIMERS  = 16;
  localparam int TIME_BITS   = 48;
  localparam int PERIOD_BITS = 32;
  localparam int ID_BITS     = $clog2(MAX_TIMERS);
  localparam int CNT_BITS    = $clog2(MAX_TIMERS + 1);
  localparam int SUM_BITS    = ((TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS) + 1;
  localparam int ENTRY_BITS  = TIME_BITS + ID_BITS;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_STALE    = 3'd6;

  typedef struct packed {
    logic [1:0]             action;
    logic [TIME_BITS-1:0]   deadline;
    logic [PERIOD_BITS-1:0] repeat_period;
    logic [ID_BITS-1:0]     target_id;
    logic [TIME_BITS-1:0]   now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ID_BITS-1:0]   result_id;
    logic [TIME_BITS-1:0] fire_time;
  } rsp_t;

  // one heap entry as read back from memory, tagged with its slot
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] deadline;
    logic [ID_BITS-1:0]   owner;
    logic [ID_BITS-1:0]   slot;
  } sample_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_SCAN, S_SCAN_END, S_CHECK, S_POP, S_REARM, S_DONE
  } state_t;

endpackage

/* design/ptq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/ptq_min_scan.sv */
// Running minimum over heap entries streamed from memory, one per cycle.
// Depends on ptq_pkg. Ties on deadline go to the smaller owner id.
module ptq_min_scan (
  input  logic                          clk,
  input  logic                          start,
  input  ptq_pkg::sample_t              sample,
  output logic [ptq_pkg::TIME_BITS-1:0] best_deadline,
  output logic [ptq_pkg::ID_BITS-1:0]   best_owner,
  output logic [ptq_pkg::ID_BITS-1:0]   best_slot
);
  logic have;
  logic take;

  always_comb begin
    take = sample.valid && (!have || (sample.deadline < best_deadline) ||
           ((sample.deadline == best_deadline) && (sample.owner < best_owner)));
  end

  always_ff @(posedge clk) begin
    if (start) begin
      have <= 1'b0;
    end else if (take) begin
      have          <= 1'b1;
      best_deadline <= sample.deadline;
      best_owner    <= sample.owner;
      best_slot     <= sample.slot;
    end
  end
endmodule

/* design/periodic_timer_queue.sv */
// Periodic timer queue: pending expiries in a RAM, scanned linearly for the earliest.
// Add reads the free stack when it reuses an id, then writes the heap; remove and clear
// respond directly; tick scans pending entries, then checks, pops if due and may re-arm.
// One item at a time; the next is taken once the previous result is registered.
// Throughput is set by the heap RAM read port during the tick scan.
// Synchronous reset empties queue, free stack and id counter; RAM contents stay undefined.
// Depends on ptq_pkg, ptq_ram, ptq_min_scan.
module periodic_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ptq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ptq_pkg::rsp_t  rsp
);
  localparam int TB = ptq_pkg::TIME_BITS;
  localparam int IB = ptq_pkg::ID_BITS;
  localparam int CB = ptq_pkg::CNT_BITS;
  localparam int SB = ptq_pkg::SUM_BITS;

  ptq_pkg::state_t state, state_next;
  ptq_pkg::req_t   item;
  ptq_pkg::rsp_t   res;
  ptq_pkg::rsp_t   res_init;

  logic [CB-1:0] heap_count, free_count, ids_issued, scan_idx;
  logic [ptq_pkg::MAX_TIMERS-1:0] entry_valid;
  logic [IB-1:0] new_id;
  logic [TB-1:0] next_deadline;
  logic          accept;
  logic          samp_v;
  logic [IB-1:0] samp_slot;

  // RAM ports
  logic                         heap_we, per_we, free_we;
  logic [IB-1:0]                heap_waddr, heap_raddr, per_waddr, per_raddr;
  logic [IB-1:0]                free_waddr, free_raddr;
  logic [ptq_pkg::ENTRY_BITS-1:0] heap_wdata, heap_rdata;
  logic [ptq_pkg::PERIOD_BITS-1:0] per_rdata;
  logic [IB-1:0]                free_wdata, free_rdata;

  logic [TB-1:0]    best_deadline;
  logic [IB-1:0]    best_owner, best_slot;
  ptq_pkg::sample_t sample;
  logic [SB-1:0]    rearm_sum;
  logic             due;
  logic             out_free;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign due      = !(item.now_time < best_deadline);
  assign rearm_sum = SB'(best_deadline) + SB'(per_rdata);

  ptq_ram #(.WIDTH(ptq_pkg::ENTRY_BITS), .DEPTH(ptq_pkg::MAX_TIMERS)) u_heap (
    .clk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );
  ptq_ram #(.WIDTH(ptq_pkg::PERIOD_BITS), .DEPTH(ptq_pkg::MAX_TIMERS)) u_period (
    .clk, .we(per_we), .waddr(per_waddr), .wdata(item.repeat_period),
    .raddr(per_raddr), .rdata(per_rdata)
  );
  ptq_ram #(.WIDTH(IB), .DEPTH(ptq_pkg::MAX_TIMERS)) u_free (
    .clk, .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  always_comb begin
    sample.valid    = samp_v;
    sample.deadline = heap_rdata[ptq_pkg::ENTRY_BITS-1:IB];
    sample.owner    = heap_rdata[IB-1:0];
    sample.slot     = samp_slot;
  end

  ptq_min_scan u_scan (
    .clk, .start(accept), .sample,
    .best_deadline, .best_owner, .best_slot
  );

  // result known at accept time for add-full, remove and clear
  always_comb begin
    res_init = '{status: ptq_pkg::ST_IDLE, result_id: '0, fire_time: '0};
    case (req.action)
      ptq_pkg::ACT_ADD: begin
        if (free_count == '0 && !(ids_issued < CB'(ptq_pkg::MAX_TIMERS)))
          res_init.status = ptq_pkg::ST_FULL;
      end
      ptq_pkg::ACT_REMOVE: begin
        res_init.result_id = req.target_id;
        res_init.status = (CB'(req.target_id) < ids_issued) ?
                          ptq_pkg::ST_REMOVED : ptq_pkg::ST_REJECTED;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptq_pkg::S_IDLE: begin
        if (accept) begin
          case (req.action)
            ptq_pkg::ACT_ADD: begin
              if (free_count != '0) state_next = ptq_pkg::S_ADD_RD;
              else if (ids_issued < CB'(ptq_pkg::MAX_TIMERS)) state_next = ptq_pkg::S_ADD_WR;
              else state_next = ptq_pkg::S_DONE;
            end
            ptq_pkg::ACT_TICK: begin
              state_next = (heap_count == '0) ? ptq_pkg::S_DONE : ptq_pkg::S_SCAN;
            end
            default: state_next = ptq_pkg::S_DONE;
          endcase
        end
      end
      ptq_pkg::S_ADD_RD:   state_next = ptq_pkg::S_ADD_WR;
      ptq_pkg::S_ADD_WR:   state_next = ptq_pkg::S_DONE;
      ptq_pkg::S_SCAN: begin
        if (scan_idx == heap_count - CB'(1)) state_next = ptq_pkg::S_SCAN_END;
      end
      ptq_pkg::S_SCAN_END: state_next = ptq_pkg::S_CHECK;
      ptq_pkg::S_CHECK:    state_next = due ? ptq_pkg::S_POP : ptq_pkg::S_DONE;
      ptq_pkg::S_POP: begin
        state_next = (entry_valid[best_owner] && per_rdata != '0) ?
                     ptq_pkg::S_REARM : ptq_pkg::S_DONE;
      end
      ptq_pkg::S_REARM:    state_next = ptq_pkg::S_DONE;
      ptq_pkg::S_DONE:     if (out_free) state_next = ptq_pkg::S_IDLE;
      default:             state_next = ptq_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    req_stall  = (state != ptq_pkg::S_IDLE);
    heap_we    = 1'b0;
    heap_waddr = heap_count[IB-1:0];
    heap_wdata = {item.deadline, new_id};
    heap_raddr = scan_idx[IB-1:0];
    per_we     = 1'b0;
    per_waddr  = new_id;
    per_raddr  = best_owner;
    free_we    = 1'b0;
    free_waddr = free_count[IB-1:0];
    free_wdata = best_owner;
    free_raddr = free_count[IB-1:0] - IB'(1);
    case (state)
      ptq_pkg::S_ADD_WR: begin
        heap_we = 1'b1;
        per_we  = 1'b1;
      end
      ptq_pkg::S_CHECK: begin
        heap_raddr = heap_count[IB-1:0] - IB'(1);
      end
      ptq_pkg::S_POP: begin
        heap_we    = 1'b1;
        heap_waddr = best_slot;
        heap_wdata = heap_rdata;
        free_we    = !entry_valid[best_owner] || (per_rdata == '0);
      end
      ptq_pkg::S_REARM: begin
        heap_we    = 1'b1;
        heap_wdata = {next_deadline, best_owner};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ptq_pkg::S_IDLE;
      heap_count  <= '0;
      free_count  <= '0;
      ids_issued  <= '0;
      entry_valid <= '0;
      rsp_valid   <= 1'b0;
      samp_v      <= 1'b0;
    end else begin
      state     <= state_next;
      samp_v    <= (state == ptq_pkg::S_SCAN);
      samp_slot <= scan_idx[IB-1:0];
      if (rsp_valid && !rsp_stall && state != ptq_pkg::S_DONE) rsp_valid <= 1'b0;
      case (state)
        ptq_pkg::S_IDLE: begin
          if (accept) begin
            item     <= req;
            scan_idx <= '0;
            res      <= res_init;
            case (req.action)
              ptq_pkg::ACT_ADD: begin
                if (free_count != '0) begin
                  free_count <= free_count - CB'(1);
                end else if (ids_issued < CB'(ptq_pkg::MAX_TIMERS)) begin
                  new_id     <= ids_issued[IB-1:0];
                  ids_issued <= ids_issued + CB'(1);
                end
              end
              ptq_pkg::ACT_REMOVE: begin
                if (CB'(req.target_id) < ids_issued) begin
                  entry_valid[req.target_id] <= 1'b0;
                end
              end
              ptq_pkg::ACT_CLEAR: begin
                heap_count  <= '0;
                free_count  <= '0;
                ids_issued  <= '0;
                entry_valid <= '0;
              end
              default: ;
            endcase
          end
        end
        ptq_pkg::S_ADD_RD: new_id <= free_rdata;
        ptq_pkg::S_ADD_WR: begin
          entry_valid[new_id] <= 1'b1;
          heap_count <= heap_count + CB'(1);
          res.status    <= ptq_pkg::ST_ADDED;
          res.result_id <= new_id;
        end
        ptq_pkg::S_SCAN: scan_idx <= scan_idx + CB'(1);
        ptq_pkg::S_CHECK: begin
          if (due) heap_count <= heap_count - CB'(1);
        end
        ptq_pkg::S_POP: begin
          res.result_id <= best_owner;
          res.fire_time <= best_deadline;
          if (!entry_valid[best_owner]) begin
            res.status <= ptq_pkg::ST_STALE;
            free_count <= free_count + CB'(1);
          end else begin
            res.status <= ptq_pkg::ST_FIRED;
            if (per_rdata == '0) begin
              entry_valid[best_owner] <= 1'b0;
              free_count <= free_count + CB'(1);
            end
          end
          // saturating re-arm
          next_deadline <= (rearm_sum[SB-1:TB] != '0) ? {TB{1'b1}} : rearm_sum[TB-1:0];
        end
        ptq_pkg::S_REARM: heap_count <= heap_count + CB'(1);
        ptq_pkg::S_DONE: begin
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_heap_le_issued: assert property (@(posedge clk) disable iff (rst)
    heap_count <= ids_issued) else $error("more pending entries than ids issued");
  a_free_le_issued: assert property (@(posedge clk) disable iff (rst)
    free_count <= ids_issued) else $error("free stack deeper than ids issued");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ptq_pkg::ST_STALE) else $error("bad status code");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall) else $error("second item taken while busy");
endmodule

/* dv/periodic_timer_queue_tb.sv */
// Testbench for periodic_timer_queue: directed table, then random add/remove/tick/clear.
// Responses are checked against an in-bench timer scheduler model, or against typed-in values for directed rows.
// Depends on ptq_pkg and the periodic_timer_queue RTL.
module periodic_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS   = ptq_pkg::TIME_BITS;
  localparam int PERIOD_BITS = ptq_pkg::PERIOD_BITS;
  localparam int ID_BITS     = ptq_pkg::ID_BITS;
  localparam int MAX_TIMERS  = ptq_pkg::MAX_TIMERS;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ptq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ptq_pkg::rsp_t rsp;

  periodic_timer_queue dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #4 clk = ~clk;

  // scheduler state mirror
  logic [TIME_BITS-1:0]   pend_time [MAX_TIMERS];
  logic [ID_BITS-1:0]     pend_id   [MAX_TIMERS];
  int                     pend_cnt;
  logic                   armed     [MAX_TIMERS];
  logic [PERIOD_BITS-1:0] period_of [MAX_TIMERS];
  logic [ID_BITS-1:0]     spare_ids [MAX_TIMERS];
  int                     spare_cnt;
  int                     issued;

  ptq_pkg::rsp_t rsp_expected [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;

  function automatic ptq_pkg::rsp_t schedule_step(ptq_pkg::req_t r);
    ptq_pkg::rsp_t o;
    int k;
    logic [ID_BITS-1:0] id;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS:0] sum;
    o = '0;
    o.status = ptq_pkg::ST_IDLE;
    case (r.action)
      ptq_pkg::ACT_ADD: begin
        if (spare_cnt > 0) begin
          spare_cnt--;
          id = spare_ids[spare_cnt];
        end else if (issued < MAX_TIMERS) begin
          id = issued[ID_BITS-1:0];
          issued++;
        end else begin
          o.status = ptq_pkg::ST_FULL;
          return o;
        end
        armed[id] = 1'b1;
        period_of[id] = r.repeat_period;
        if (pend_cnt < MAX_TIMERS) begin
          pend_time[pend_cnt] = r.deadline;
          pend_id[pend_cnt] = id;
          pend_cnt++;
        end
        o.status = ptq_pkg::ST_ADDED;
        o.result_id = id;
      end
      ptq_pkg::ACT_REMOVE: begin
        o.result_id = r.target_id;
        if (r.target_id < issued) begin
          armed[r.target_id] = 1'b0;
          o.status = ptq_pkg::ST_REMOVED;
        end else begin
          o.status = ptq_pkg::ST_REJECTED;
        end
      end
      ptq_pkg::ACT_TICK: begin
        if (pend_cnt == 0) return o;
        k = 0;
        for (int i = 1; i < pend_cnt; i++)
          if (pend_time[i] < pend_time[k] ||
              (pend_time[i] == pend_time[k] && pend_id[i] < pend_id[k]))
            k = i;
        t = pend_time[k];
        if (r.now_time < t) return o;
        id = pend_id[k];
        pend_cnt--;
        pend_time[k] = pend_time[pend_cnt];
        pend_id[k] = pend_id[pend_cnt];
        o.result_id = id;
        o.fire_time = t;
        if (!armed[id]) begin
          spare_ids[spare_cnt] = id;
          spare_cnt++;
          o.status = ptq_pkg::ST_STALE;
        end else begin
          if (period_of[id] != 0) begin
            sum = {1'b0, t} + period_of[id];
            pend_time[pend_cnt] = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
            pend_id[pend_cnt] = id;
            pend_cnt++;
          end else begin
            armed[id] = 1'b0;
            spare_ids[spare_cnt] = id;
            spare_cnt++;
          end
          o.status = ptq_pkg::ST_FIRED;
        end
      end
      default: begin
        for (int i = 0; i < MAX_TIMERS; i++) armed[i] = 1'b0;
        pend_cnt = 0;
        spare_cnt = 0;
        issued = 0;
      end
    endcase
    return o;
  endfunction

  // directed rows; check_fixed marks rows whose response is typed in
  typedef struct {
    ptq_pkg::req_t r;
    bit            check_fixed;
    ptq_pkg::rsp_t fixed;
  } row_t;

  function automatic ptq_pkg::req_t mk(logic [1:0] a, logic [TIME_BITS-1:0] d,
                                       logic [PERIOD_BITS-1:0] p, logic [ID_BITS-1:0] id,
                                       logic [TIME_BITS-1:0] n);
    ptq_pkg::req_t r;
    r.action = a; r.deadline = d; r.repeat_period = p; r.target_id = id; r.now_time = n;
    return r;
  endfunction

  function automatic ptq_pkg::rsp_t rs(logic [2:0] s, logic [ID_BITS-1:0] id,
                                       logic [TIME_BITS-1:0] t);
    ptq_pkg::rsp_t o;
    o.status = s; o.result_id = id; o.fire_time = t;
    return o;
  endfunction

  row_t directed [$];
  ptq_pkg::req_t stim [$];

  task automatic add_row(row_t x);
    directed.insert(directed.size(), x);
  endtask

  task automatic build_directed();
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, TIME_MAX), 1, rs(ptq_pkg::ST_IDLE, 0, 0)});
    add_row('{mk(ptq_pkg::ACT_REMOVE, 0, 0, 0, 0), 1, rs(ptq_pkg::ST_REJECTED, 0, 0)});
    add_row('{mk(ptq_pkg::ACT_ADD, 100, 0, 0, 0), 1, rs(ptq_pkg::ST_ADDED, 0, 0)});
    add_row('{mk(ptq_pkg::ACT_ADD, TIME_MAX - 5, '1, 15, 0), 1,
              rs(ptq_pkg::ST_ADDED, 1, 0)});
    add_row('{mk(ptq_pkg::ACT_ADD, 100, 7, 0, 0), 1, rs(ptq_pkg::ST_ADDED, 2, 0)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, 99), 1, rs(ptq_pkg::ST_IDLE, 0, 0)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, 100), 1, rs(ptq_pkg::ST_FIRED, 0, 100)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, 100), 1, rs(ptq_pkg::ST_FIRED, 2, 100)});
    add_row('{mk(ptq_pkg::ACT_REMOVE, 0, 0, 2, 0), 1, rs(ptq_pkg::ST_REMOVED, 2, 0)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, 200), 1, rs(ptq_pkg::ST_STALE, 2, 107)});
    add_row('{mk(ptq_pkg::ACT_REMOVE, 0, 0, 15, 0), 1, rs(ptq_pkg::ST_REJECTED, 15, 0)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, TIME_MAX), 1,
              rs(ptq_pkg::ST_FIRED, 1, TIME_MAX - 5)});
    // saturated re-arm fires at the top of time
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, TIME_MAX), 1,
              rs(ptq_pkg::ST_FIRED, 1, TIME_MAX)});
    add_row('{mk(ptq_pkg::ACT_CLEAR, '1, '1, '1, '1), 1, rs(ptq_pkg::ST_IDLE, 0, 0)});
    for (int i = 0; i < MAX_TIMERS; i++)
      add_row('{mk(ptq_pkg::ACT_ADD, 50, 0, 0, 0), 0, '0});
    add_row('{mk(ptq_pkg::ACT_ADD, 1, 1, 0, 0), 1, rs(ptq_pkg::ST_FULL, 0, 0)});
    add_row('{mk(ptq_pkg::ACT_REMOVE, 0, 0, 15, 0), 1, rs(ptq_pkg::ST_REMOVED, 15, 0)});
    add_row('{mk(ptq_pkg::ACT_TICK, 0, 0, 0, 50), 1, rs(ptq_pkg::ST_FIRED, 0, 50)});
    add_row('{mk(ptq_pkg::ACT_ADD, 0, 0, 0, 0), 1, rs(ptq_pkg::ST_ADDED, 0, 0)});
  endtask

  function automatic logic [TIME_BITS-1:0] rand_time(logic [TIME_BITS-1:0] base);
    case ($urandom_range(0, 7))
      0: return TIME_BITS'({$urandom(), $urandom()});
      1: return TIME_MAX - $urandom_range(0, 3);
      2: return '0;
      default: return base + $urandom_range(0, 60);
    endcase
  endfunction

  function automatic ptq_pkg::req_t rand_item(ref logic [TIME_BITS-1:0] clock_now);
    ptq_pkg::req_t r;
    int pick;
    r = '0;
    r.deadline = TIME_BITS'({$urandom(), $urandom()});
    r.repeat_period = $urandom();
    r.target_id = ID_BITS'($urandom());
    r.now_time = TIME_BITS'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      r.action = ptq_pkg::ACT_ADD;
      r.deadline = rand_time(clock_now);
      case ($urandom_range(0, 3))
        0: r.repeat_period = '0;
        1: r.repeat_period = $urandom_range(1, 30);
        2: ;
        default: r.repeat_period = $urandom_range(0, 1) ? '1 : '0;
      endcase
    end else if (pick < 50) begin
      r.action = ptq_pkg::ACT_REMOVE;
    end else if (pick < 98) begin
      r.action = ptq_pkg::ACT_TICK;
      if ($urandom_range(0, 9) != 0) begin
        clock_now = clock_now + $urandom_range(0, 20);
        r.now_time = clock_now;
      end
    end else begin
      r.action = ptq_pkg::ACT_CLEAR;
      clock_now = $urandom_range(0, 1) ? '0 : TIME_BITS'({$urandom(), $urandom()});
    end
    return r;
  endfunction

  // sender
  initial begin
    logic [TIME_BITS-1:0] clock_now;
    clock_now = '0;
    build_directed();
    foreach (directed[i]) stim.insert(stim.size(), directed[i].r);
    for (int i = 0; i < 600; i++) stim.insert(stim.size(), rand_item(clock_now));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < stim.size(); i++) begin
      // idling phases by position
      if (i == directed.size() + 100) send_idle_pct = 80;
      if (i == directed.size() + 200) begin send_idle_pct = 0; recv_stall_pct = 80; end
      if (i == directed.size() + 300) begin send_idle_pct = 31; recv_stall_pct = 31; end
      if (i == directed.size() + 400) begin send_idle_pct = 0; recv_stall_pct = 0; end
      if (i == directed.size() + 450) hold_off = 1'b1;
      if (i == directed.size() + 500) begin send_idle_pct = 31; recv_stall_pct = 31; end
      while ($urandom_range(0, 99) < send_idle_pct) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      req_valid <= 1'b1;
      req <= stim[i];
      @(posedge clk);
      while (req_stall) @(posedge clk);
    end
    req_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // receiver stall, with one long hold-off
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        held = 0;
        rsp_stall <= 1'b1;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // predict on accepted input beats, check on accepted output beats
  int row_idx = 0;
  always @(posedge clk) begin
    ptq_pkg::rsp_t e;
    ptq_pkg::rsp_t want;
    if (!rst && req_valid && !req_stall) begin
      e = schedule_step(req);
      if (row_idx < directed.size() && directed[row_idx].check_fixed)
        e = directed[row_idx].fixed;
      row_idx++;
      rsp_expected.insert(rsp_expected.size(), e);
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat %p", rsp);
      end else begin
        want = rsp_expected.pop_front();
        if (rsp.status !== want.status || rsp.result_id !== want.result_id ||
            rsp.fire_time !== want.fire_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d id=%0d t=%0d, got st=%0d id=%0d t=%0d",
                     want.status, want.result_id, want.fire_time,
                     rsp.status, rsp.result_id, rsp.fire_time);
        end
      end
    end
  end

  initial begin
    pend_cnt = 0;
    spare_cnt = 0;
    issued = 0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      armed[i] = 1'b0;
      period_of[i] = '0;
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
design/ptq_pkg.sv
design/ptq_ram.sv
design/ptq_min_scan.sv
design/periodic_timer_queue.sv
dv/periodic_timer_queue_tb.sv
